// ----- hdl/smbios_structure_walker_assert.svh -----
// assertion helpers for the structure walker
`ifndef SMBIOS_STRUCTURE_WALKER_ASSERT_SVH
`define SMBIOS_STRUCTURE_WALKER_ASSERT_SVH

// same-cycle implication, off while in reset
`define SSW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define SSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ssw_pkg.sv -----
`default_nettype none

package ssw_pkg;

    // defaults for the top level parameters
    localparam int TYPE_SLOTS_DEF  = 128;
    localparam int OFFSET_BITS_DEF = 16;

    // input function codes
    localparam logic [1:0] FUNC_BYTE    = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP  = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    // classified operations carried through the queue
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // parse phases
    localparam logic [1:0] PH_HEADER    = 2'd0;
    localparam logic [1:0] PH_FORMATTED = 2'd1;
    localparam logic [1:0] PH_STRINGS   = 2'd2;

    // stop reasons
    localparam logic [2:0] STOP_NONE      = 3'd0;
    localparam logic [2:0] STOP_END_TYPE  = 3'd1;
    localparam logic [2:0] STOP_COUNT     = 3'd2;
    localparam logic [2:0] STOP_BYTES     = 3'd3;
    localparam logic [2:0] STOP_MALFORMED = 3'd4;

    // result kinds
    localparam logic KIND_STRUCT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [7:0] END_TYPE   = 8'd127;
    localparam logic [7:0] ZERO_BYTE  = 8'd0;
    localparam logic [7:0] HEADER_LEN = 8'd4;

    // configuration registers
    localparam int         CFG_IDX_W        = 1;
    localparam int         CFG_DATA_W       = 16;
    localparam logic [0:0] CFG_COUNT_LIMIT  = 1'b0;
    localparam logic [0:0] CFG_BYTE_LIMIT   = 1'b1;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic [6:0] query_type;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [7:0]  struct_type;
        logic [15:0] struct_handle;
        logic [15:0] start_offset;
        logic [15:0] struct_size;
        logic [2:0]  stop_reason;
        logic        found;
    } t_out;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic [6:0] query_type;
    } t_cmd;

    // queue head seen by the back end
    typedef struct packed {
        logic avail;
        t_cmd cmd;
    } t_q_head;

    // front end push request
    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_push;

endpackage

`default_nettype wire

// ----- hdl/ssw_front.sv -----
`default_nettype none

module ssw_front (
    input  wire             i_in_valid,
    input  ssw_pkg::t_in    i_in_data,
    output logic            o_in_ready,
    input  wire             i_q_full,
    output ssw_pkg::t_q_push o_q_push
);

    logic w_accept;

    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;

    always_comb begin
        o_q_push.push           = 1'b0;
        o_q_push.cmd.op         = ssw_pkg::OP_BYTE;
        o_q_push.cmd.data_byte  = i_in_data.data_byte;
        o_q_push.cmd.query_type = i_in_data.query_type;
        unique case (i_in_data.func)
            ssw_pkg::FUNC_BYTE: begin
                o_q_push.push   = w_accept;
                o_q_push.cmd.op = ssw_pkg::OP_BYTE;
            end
            ssw_pkg::FUNC_LOOKUP: begin
                o_q_push.push   = w_accept;
                o_q_push.cmd.op = ssw_pkg::OP_LOOKUP;
            end
            ssw_pkg::FUNC_RESTART: begin
                o_q_push.push   = w_accept;
                o_q_push.cmd.op = ssw_pkg::OP_CLEAR;
            end
            // unused code is taken and dropped here
            default: begin
                o_q_push.push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/ssw_queue.sv -----
`default_nettype none

module ssw_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  ssw_pkg::t_q_push i_q_push,
    input  wire              i_pop,
    output logic             o_full,
    output ssw_pkg::t_q_head o_head
);

    ssw_pkg::t_cmd r_entry [ssw_pkg::Q_DEPTH];
    logic [ssw_pkg::Q_PTR_W-1:0] r_wptr;
    logic [ssw_pkg::Q_PTR_W-1:0] r_rptr;
    logic [ssw_pkg::Q_CNT_W-1:0] r_count;
    logic [ssw_pkg::Q_CNT_W-1:0] n_count;
    logic w_push;
    logic w_pop;

    assign o_full      = (r_count == ssw_pkg::Q_CNT_W'(ssw_pkg::Q_DEPTH));
    assign w_push      = i_q_push.push && !o_full;
    assign w_pop       = i_pop && (r_count != '0);
    assign o_head.avail = (r_count != '0);
    assign o_head.cmd   = r_entry[r_rptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wptr] <= i_q_push.cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ssw_back.sv -----
`default_nettype none

module ssw_back #(
    parameter int TYPE_SLOTS  = ssw_pkg::TYPE_SLOTS_DEF,
    parameter int OFFSET_BITS = ssw_pkg::OFFSET_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  ssw_pkg::t_q_head                   i_head,
    output logic                               o_pop,
    input  wire                                i_cfg_we,
    input  wire  [ssw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [ssw_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output ssw_pkg::t_out                      o_out_data
);

    localparam int SLOT_BITS = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;

    // parse state
    logic [1:0]             r_phase,   n_phase;
    logic [15:0]            r_bis,     n_bis;
    logic [7:0]             r_flen,    n_flen;
    logic [7:0]             r_ctype,   n_ctype;
    logic [15:0]            r_chandle, n_chandle;
    logic                   r_prevz,   n_prevz;
    logic [OFFSET_BITS-1:0] r_total,   n_total;
    logic [15:0]            r_done,    n_done;
    logic                   r_stopped, n_stopped;
    logic [TYPE_SLOTS-1:0]  r_slot_valid, n_slot_valid;

    logic [15:0] r_cnt_lim;
    logic [15:0] r_byte_lim;

    // offset table
    logic [OFFSET_BITS-1:0] r_offs [TYPE_SLOTS];
    logic [OFFSET_BITS-1:0] r_rd_off;

    // output register
    logic          r_out_valid;
    ssw_pkg::t_out r_out;
    logic          r_use_rd;

    ssw_pkg::t_out w_res;
    logic          w_res_v;
    logic          w_use_rd;
    logic          w_mem_we;
    logic          w_mem_re;

    logic [7:0]            w_b;
    logic [15:0]           w_bis_inc;
    logic [15:0]           w_bis_sat;
    logic [15:0]           w_done_inc;
    logic [31:0]           w_tot32;
    logic [32:0]           w_sum;
    logic [31:0]           w_rd32;
    logic [7:0]            w_qx;
    logic                  w_type_ok;
    logic                  w_q_ok;
    logic [SLOT_BITS-1:0]  w_wr_idx;
    logic [SLOT_BITS-1:0]  w_rd_idx;
    logic [2:0]            w_reason;

    assign o_pop      = i_head.avail && (!r_out_valid || i_out_ready);
    assign w_b        = i_head.cmd.data_byte;
    assign w_bis_inc  = r_bis + 16'd1;
    assign w_bis_sat  = (r_bis == 16'hFFFF) ? r_bis : w_bis_inc;
    assign w_done_inc = (r_done == 16'hFFFF) ? r_done : (r_done + 16'd1);
    assign w_tot32    = 32'(r_total);
    // end offset (start plus size) on the string byte that closes a structure
    assign w_sum      = 33'(w_tot32) + 33'(w_bis_sat);
    assign w_rd32     = 32'(r_rd_off);
    assign w_qx       = {1'b0, i_head.cmd.query_type};
    assign w_type_ok  = ({1'b0, r_ctype} < 9'(TYPE_SLOTS));
    assign w_q_ok     = ({1'b0, w_qx} < 9'(TYPE_SLOTS));
    assign w_wr_idx   = r_ctype[SLOT_BITS-1:0];
    assign w_rd_idx   = w_qx[SLOT_BITS-1:0];

    always_comb begin
        n_phase      = r_phase;
        n_bis        = r_bis;
        n_flen       = r_flen;
        n_ctype      = r_ctype;
        n_chandle    = r_chandle;
        n_prevz      = r_prevz;
        n_total      = r_total;
        n_done       = r_done;
        n_stopped    = r_stopped;
        n_slot_valid = r_slot_valid;
        w_res        = '0;
        w_res_v      = 1'b0;
        w_use_rd     = 1'b0;
        w_mem_we     = 1'b0;
        w_mem_re     = 1'b0;
        w_reason     = ssw_pkg::STOP_NONE;

        if (o_pop) begin
            unique case (i_head.cmd.op)
                ssw_pkg::OP_CLEAR: begin
                    n_phase      = ssw_pkg::PH_HEADER;
                    n_bis        = '0;
                    n_flen       = '0;
                    n_ctype      = '0;
                    n_chandle    = '0;
                    n_prevz      = 1'b0;
                    n_total      = '0;
                    n_done       = '0;
                    n_stopped    = 1'b0;
                    n_slot_valid = '0;
                end
                ssw_pkg::OP_LOOKUP: begin
                    w_res_v    = 1'b1;
                    w_res.kind = ssw_pkg::KIND_LOOKUP;
                    w_mem_re   = 1'b1;
                    if (w_q_ok && r_slot_valid[w_rd_idx]) begin
                        w_res.found = 1'b1;
                        w_use_rd    = 1'b1;
                    end
                end
                ssw_pkg::OP_BYTE: begin
                    if (!r_stopped) begin
                        unique case (r_phase)
                            ssw_pkg::PH_HEADER: begin
                                n_bis = w_bis_inc;
                                unique case (r_bis[1:0])
                                    2'd0: begin
                                        n_ctype   = w_b;
                                        n_chandle = '0;
                                    end
                                    2'd1: n_flen    = w_b;
                                    2'd2: n_chandle = {8'd0, w_b};
                                    default: n_chandle = {w_b, r_chandle[7:0]};
                                endcase
                                if (r_bis[1:0] == 2'd3) begin
                                    n_prevz = 1'b0;
                                    if (r_flen < ssw_pkg::HEADER_LEN) begin
                                        // header only, length field too short
                                        w_res_v             = 1'b1;
                                        w_res.kind          = ssw_pkg::KIND_STRUCT;
                                        w_res.struct_type   = r_ctype;
                                        w_res.struct_handle = n_chandle;
                                        w_res.start_offset  = w_tot32[15:0];
                                        w_res.struct_size   = 16'(ssw_pkg::HEADER_LEN);
                                        w_res.stop_reason   =
                                            (r_ctype == ssw_pkg::END_TYPE) ?
                                            ssw_pkg::STOP_END_TYPE :
                                            ssw_pkg::STOP_MALFORMED;
                                        n_stopped = 1'b1;
                                        n_bis     = '0;
                                        n_phase   = ssw_pkg::PH_HEADER;
                                    end else if (r_flen == ssw_pkg::HEADER_LEN) begin
                                        n_phase = ssw_pkg::PH_STRINGS;
                                    end else begin
                                        n_phase = ssw_pkg::PH_FORMATTED;
                                    end
                                end
                            end
                            ssw_pkg::PH_FORMATTED: begin
                                n_bis = w_bis_inc;
                                if (w_bis_inc >= {8'd0, r_flen}) begin
                                    n_phase = ssw_pkg::PH_STRINGS;
                                    n_prevz = 1'b0;
                                end
                            end
                            ssw_pkg::PH_STRINGS: begin
                                n_bis = w_bis_sat;
                                if (w_b == ssw_pkg::ZERO_BYTE && r_prevz) begin
                                    // double zero closes the structure
                                    if (r_ctype == ssw_pkg::END_TYPE) begin
                                        w_reason = ssw_pkg::STOP_END_TYPE;
                                    end else begin
                                        if (w_type_ok) begin
                                            n_slot_valid[w_wr_idx] = 1'b1;
                                            w_mem_we               = 1'b1;
                                        end
                                        if (r_byte_lim != '0 &&
                                            w_sum >= 33'(r_byte_lim)) begin
                                            w_reason = ssw_pkg::STOP_BYTES;
                                        end else begin
                                            n_done = w_done_inc;
                                            if (r_cnt_lim != '0 && w_done_inc >= r_cnt_lim) begin
                                                w_reason = ssw_pkg::STOP_COUNT;
                                            end
                                        end
                                    end
                                    w_res_v             = 1'b1;
                                    w_res.kind          = ssw_pkg::KIND_STRUCT;
                                    w_res.struct_type   = r_ctype;
                                    w_res.struct_handle = r_chandle;
                                    w_res.start_offset  = w_tot32[15:0];
                                    w_res.struct_size   = w_bis_sat;
                                    w_res.stop_reason   = w_reason;
                                    if (w_reason != ssw_pkg::STOP_NONE) begin
                                        n_stopped = 1'b1;
                                    end else begin
                                        n_total = w_sum[OFFSET_BITS-1:0];
                                    end
                                    n_phase = ssw_pkg::PH_HEADER;
                                    n_bis   = '0;
                                    n_prevz = 1'b0;
                                end else begin
                                    n_prevz = (w_b == ssw_pkg::ZERO_BYTE);
                                end
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ssw_pkg::PH_HEADER;
            r_bis        <= '0;
            r_flen       <= '0;
            r_ctype      <= '0;
            r_chandle    <= '0;
            r_prevz      <= 1'b0;
            r_total      <= '0;
            r_done       <= '0;
            r_stopped    <= 1'b0;
            r_slot_valid <= '0;
            r_cnt_lim    <= '0;
            r_byte_lim   <= '0;
            r_out_valid  <= 1'b0;
            r_use_rd     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bis        <= n_bis;
            r_flen       <= n_flen;
            r_ctype      <= n_ctype;
            r_chandle    <= n_chandle;
            r_prevz      <= n_prevz;
            r_total      <= n_total;
            r_done       <= n_done;
            r_stopped    <= n_stopped;
            r_slot_valid <= n_slot_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ssw_pkg::CFG_COUNT_LIMIT: r_cnt_lim  <= i_cfg_wdata;
                    default:                  r_byte_lim <= i_cfg_wdata;
                endcase
            end
            if (o_pop) begin
                r_out_valid <= w_res_v;
                r_use_rd    <= w_use_rd;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= w_res;
        end
    end

    // offset table: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_offs[w_wr_idx] <= r_total;
        end
        if (w_mem_re) begin
            r_rd_off <= r_offs[w_rd_idx];
        end
    end

    always_comb begin
        o_out_data = r_out;
        if (r_use_rd) begin
            o_out_data.start_offset = w_rd32[15:0];
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- hdl/smbios_structure_walker.sv -----
// smbios_structure_walker
// input channel: one item per transfer on i_in_valid / o_in_ready. func selects a
// table byte, a lookup of the offset recorded for query_type, or a restart that
// clears the parse state, counters and the type table. the unused func code is
// taken and dropped.
// output channel: one result per transfer on o_out_valid / i_out_ready: a
// structure report (kind 0) when a structure closes or parsing stops, or a
// lookup answer (kind 1).
// configuration: i_cfg_we writes the count limit (index 0) or byte limit
// (index 1); write only while no item is in flight.
// throughput: one item per clock while the output is not held; the limit is the
// combinational parse update and the one-write one-read offset table.
// path: a taken item is written into the queue, then its result is registered in the
// output register when the back end pops it, which waits while a result is held.
// reset: limits zero, table entries invalid, parser waits for a header byte.
// stall: with the output held the queue fills and o_in_ready drops once two
// items wait behind the held result; nothing is lost.
`default_nettype none

module smbios_structure_walker #(
    parameter int TYPE_SLOTS  = ssw_pkg::TYPE_SLOTS_DEF,
    parameter int OFFSET_BITS = ssw_pkg::OFFSET_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  ssw_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output ssw_pkg::t_out                  o_out_data,
    input  wire                            i_cfg_we,
    input  wire  [ssw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [ssw_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

`include "smbios_structure_walker_assert.svh"

    ssw_pkg::t_q_push w_q_push;
    ssw_pkg::t_q_head w_q_head;
    logic             w_q_full;
    logic             w_pop;

    ssw_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push)
    );

    ssw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_push (w_q_push),
        .i_pop    (w_pop),
        .o_full   (w_q_full),
        .o_head   (w_q_head)
    );

    ssw_back #(
        .TYPE_SLOTS  (TYPE_SLOTS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_q_head),
        .o_pop       (w_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    `SSW_ASSERT_NOW(a_pop_needs_item, i_clk, i_rst_n, w_pop, w_q_head.avail, "pop from empty queue")
    `SSW_ASSERT_NOW(a_pop_needs_slot, i_clk, i_rst_n, w_pop, (!o_out_valid || i_out_ready), "pop while result held")
    `SSW_ASSERT_NOW(a_push_is_transfer, i_clk, i_rst_n, w_q_push.push, (i_in_valid && o_in_ready), "push without input transfer")
    `SSW_ASSERT_NOW(a_miss_has_no_offset, i_clk, i_rst_n, (o_out_valid && o_out_data.kind == ssw_pkg::KIND_LOOKUP && !o_out_data.found), (o_out_data.start_offset == 16'd0), "lookup miss with offset")
    `SSW_ASSERT_NOW(a_report_not_found, i_clk, i_rst_n, (o_out_valid && o_out_data.kind == ssw_pkg::KIND_STRUCT), (!o_out_data.found), "structure report with found set")

endmodule

`default_nettype wire
